[design/s208_pkg.sv]
`default_nettype none
package s208_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumWords = 16;
  localparam int unsigned PairW   = 64;
  localparam int unsigned DRounds = 4;
  localparam int unsigned StepsPerHalf = 4;
  localparam int unsigned NumCells = DRounds * 2 * StepsPerHalf;

  typedef logic [WordW-1:0] word_t;
  typedef word_t [NumWords-1:0] block_t;
  typedef logic [3:0] idx_t;
  typedef logic [1:0] role_t;

  typedef struct packed {
    logic   valid;
    block_t blk;
    block_t orig;
  } stage_t;

  // quarter roles
  localparam role_t RoleA = 2'd0;
  localparam role_t RoleB = 2'd1;
  localparam role_t RoleC = 2'd2;
  localparam role_t RoleD = 2'd3;

  // [role][quarter]
  localparam idx_t [0:3][0:3] ColIdx = '{
    '{4'd0,  4'd5,  4'd10, 4'd15},
    '{4'd4,  4'd9,  4'd14, 4'd3},
    '{4'd8,  4'd13, 4'd2,  4'd7},
    '{4'd12, 4'd1,  4'd6,  4'd11}
  };
  localparam idx_t [0:3][0:3] RowIdx = '{
    '{4'd0,  4'd5,  4'd10, 4'd15},
    '{4'd1,  4'd6,  4'd11, 4'd12},
    '{4'd2,  4'd7,  4'd8,  4'd13},
    '{4'd3,  4'd4,  4'd9,  4'd14}
  };

  localparam int unsigned RotAmt [4] = '{7, 9, 13, 18};

  function automatic idx_t word_idx(input logic is_row, input logic [1:0] q,
                                    input role_t role);
    idx_t r;
    if (is_row) begin
      r = RowIdx[role][q];
    end else begin
      r = ColIdx[role][q];
    end
    return r;
  endfunction

  function automatic word_t rotl32(input word_t v, input int unsigned n);
    return word_t'((v << n) | (v >> (WordW - n)));
  endfunction

endpackage
`default_nettype wire

[design/s208_in_if.sv]
`default_nettype none
interface s208_in_if;
  import s208_pkg::*;

  logic             valid;
  logic             ready;
  logic [PairW-1:0] word_pair_0;
  logic [PairW-1:0] word_pair_1;
  logic [PairW-1:0] word_pair_2;
  logic [PairW-1:0] word_pair_3;
  logic [PairW-1:0] word_pair_4;
  logic [PairW-1:0] word_pair_5;
  logic [PairW-1:0] word_pair_6;
  logic [PairW-1:0] word_pair_7;

  modport source (
    output valid, word_pair_0, word_pair_1, word_pair_2, word_pair_3,
           word_pair_4, word_pair_5, word_pair_6, word_pair_7,
    input  ready
  );
  modport sink (
    input  valid, word_pair_0, word_pair_1, word_pair_2, word_pair_3,
           word_pair_4, word_pair_5, word_pair_6, word_pair_7,
    output ready
  );
endinterface
`default_nettype wire

[design/s208_out_if.sv]
`default_nettype none
interface s208_out_if;
  import s208_pkg::*;

  logic             valid;
  logic             ready;
  logic [PairW-1:0] out_pair_0;
  logic [PairW-1:0] out_pair_1;
  logic [PairW-1:0] out_pair_2;
  logic [PairW-1:0] out_pair_3;
  logic [PairW-1:0] out_pair_4;
  logic [PairW-1:0] out_pair_5;
  logic [PairW-1:0] out_pair_6;
  logic [PairW-1:0] out_pair_7;

  modport source (
    output valid, out_pair_0, out_pair_1, out_pair_2, out_pair_3,
           out_pair_4, out_pair_5, out_pair_6, out_pair_7,
    input  ready
  );
  modport sink (
    input  valid, out_pair_0, out_pair_1, out_pair_2, out_pair_3,
           out_pair_4, out_pair_5, out_pair_6, out_pair_7,
    output ready
  );
endinterface
`default_nettype wire

[design/s208_cell.sv]
`default_nettype none
module s208_cell #(
  parameter bit         IsRow = 1'b0,
  parameter logic [1:0] Step  = 2'd0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  s208_pkg::stage_t up_i,
  output logic             up_ready,
  output s208_pkg::stage_t dn_o,
  input  logic             dn_ready
);
  import s208_pkg::*;

  localparam role_t       TgtRole = role_t'(Step + 2'd1);
  localparam role_t       Src1Role = role_t'(Step);
  localparam role_t       Src2Role = role_t'(Step + 2'd3);
  localparam int unsigned Rot = RotAmt[Step];

  logic   valid_r;
  logic   valid_nxt;
  block_t blk_r;
  block_t blk_nxt;
  block_t orig_r;

  // one add-rotate-xor step on all four quarters at once
  always_comb begin
    blk_nxt = up_i.blk;
    for (int q = 0; q < 4; q++) begin
      blk_nxt[word_idx(IsRow, q[1:0], TgtRole)] =
        up_i.blk[word_idx(IsRow, q[1:0], TgtRole)] ^
        rotl32(word_t'(up_i.blk[word_idx(IsRow, q[1:0], Src1Role)] +
                       up_i.blk[word_idx(IsRow, q[1:0], Src2Role)]), Rot);
    end
  end

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_i.valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_i.valid) begin
      blk_r  <= blk_nxt;
      orig_r <= up_i.orig;
    end
  end

  assign dn_o.valid = valid_r;
  assign dn_o.blk   = blk_r;
  assign dn_o.orig  = orig_r;

endmodule
`default_nettype wire

[design/s208_fin.sv]
`default_nettype none
module s208_fin (
  input  logic             clk,
  input  logic             rst_n,
  input  s208_pkg::stage_t up_i,
  output logic             up_ready,
  output logic             res_valid,
  output s208_pkg::block_t res,
  input  logic             res_ready
);
  import s208_pkg::*;

  logic   valid_r;
  logic   valid_nxt;
  block_t res_r;
  block_t res_nxt;

  // feed-forward of the original words
  always_comb begin
    for (int i = 0; i < NumWords; i++) begin
      res_nxt[i] = word_t'(up_i.blk[i] + up_i.orig[i]);
    end
  end

  assign up_ready  = !valid_r || res_ready;
  assign valid_nxt = up_ready ? up_i.valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_i.valid) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = valid_r;
  assign res       = res_r;

endmodule
`default_nettype wire

[design/salsa20_8_core_unit.sv]
// Salsa20/8 core, one 512-bit block per request.
// in_ch carries sixteen 32-bit words as eight 64-bit pairs (even word in
// the low half); out_ch returns the sixteen result words packed the same
// way. Both channels use valid/ready; a request moves when both are high.
// The rounds run down a row of 32 cells, each doing one add-rotate-xor
// step of all four quarters of a column or row round, followed by one
// output register that adds back the original words.
// A request accepted on in_ch passes through the 32 cell registers and then
// the output register. Throughput: one request per cycle while nothing stalls.
// Every stage has its own valid bit and loads when it is empty or its
// neighbor is taking its contents, so a stalled receiver only backs the
// row up as it fills; bubbles are squeezed out and in_ch keeps taking
// requests until every stage is full.
// Reset (synchronous, active low) empties all stages; no data is kept.
`default_nettype none
module salsa20_8_core_unit (
  input  logic     clk,
  input  logic     rst_n,
  s208_in_if.sink  in_ch,
  s208_out_if.source out_ch
);
  import s208_pkg::*;

  stage_t st [NumCells+1];
  logic   rdy [NumCells+1];
  block_t res;

  always_comb begin
    st[0].valid    = in_ch.valid;
    st[0].blk[0]   = in_ch.word_pair_0[31:0];
    st[0].blk[1]   = in_ch.word_pair_0[63:32];
    st[0].blk[2]   = in_ch.word_pair_1[31:0];
    st[0].blk[3]   = in_ch.word_pair_1[63:32];
    st[0].blk[4]   = in_ch.word_pair_2[31:0];
    st[0].blk[5]   = in_ch.word_pair_2[63:32];
    st[0].blk[6]   = in_ch.word_pair_3[31:0];
    st[0].blk[7]   = in_ch.word_pair_3[63:32];
    st[0].blk[8]   = in_ch.word_pair_4[31:0];
    st[0].blk[9]   = in_ch.word_pair_4[63:32];
    st[0].blk[10]  = in_ch.word_pair_5[31:0];
    st[0].blk[11]  = in_ch.word_pair_5[63:32];
    st[0].blk[12]  = in_ch.word_pair_6[31:0];
    st[0].blk[13]  = in_ch.word_pair_6[63:32];
    st[0].blk[14]  = in_ch.word_pair_7[31:0];
    st[0].blk[15]  = in_ch.word_pair_7[63:32];
    st[0].orig     = st[0].blk;
  end

  assign in_ch.ready = rdy[0];

  for (genvar j = 0; j < NumCells; j++) begin : g_cell
    s208_cell #(
      .IsRow (1'((j / StepsPerHalf) % 2)),
      .Step  (2'(j % StepsPerHalf))
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_i     (st[j]),
      .up_ready (rdy[j]),
      .dn_o     (st[j+1]),
      .dn_ready (rdy[j+1])
    );
  end

  s208_fin u_fin (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_i      (st[NumCells]),
    .up_ready  (rdy[NumCells]),
    .res_valid (out_ch.valid),
    .res       (res),
    .res_ready (out_ch.ready)
  );

  assign out_ch.out_pair_0 = {res[1],  res[0]};
  assign out_ch.out_pair_1 = {res[3],  res[2]};
  assign out_ch.out_pair_2 = {res[5],  res[4]};
  assign out_ch.out_pair_3 = {res[7],  res[6]};
  assign out_ch.out_pair_4 = {res[9],  res[8]};
  assign out_ch.out_pair_5 = {res[11], res[10]};
  assign out_ch.out_pair_6 = {res[13], res[12]};
  assign out_ch.out_pair_7 = {res[15], res[14]};

  a_accept_fills_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> st[1].valid)
    else $error("accepted request not held in first cell");

  a_last_cell_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    st[NumCells].valid && rdy[NumCells] |=> out_ch.valid)
    else $error("last cell contents lost before output register");

  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input stalled while receiver is ready");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid && !st[1].valid)
    else $error("stages not emptied by reset");

endmodule
`default_nettype wire
